// ===== rtl/core/evuhp_pkg.sv =====
package evuhp_pkg;

  // Frame byte counter and bound
  localparam int unsigned PosW          = 16;
  localparam int unsigned MaxFrameBytes = 16384;

  // Header constants
  localparam logic [15:0] EtypeVlan       = 16'h8100;
  localparam logic [15:0] EtypeIpv4       = 16'h0800;
  localparam logic [7:0]  ProtoUdp        = 8'd17;
  localparam logic [3:0]  IhlMin          = 4'd5;
  localparam logic [15:0] UdpHeaderBytes  = 16'd8;
  localparam logic [15:0] MinPayloadReset = 16'd240;

  // Smallest offset of an accepted payload: Ethernet + minimal IPv4 + UDP
  localparam logic [15:0] MinPayloadOffset = 16'd42;

  // Output tdata width: addresses, ports, offset, length
  localparam int unsigned OutDataW = 128;

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } result_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

endpackage

// ===== rtl/core/evuhp_in_stage.sv =====
module evuhp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_vld_i,
  output logic                req_rdy_o,
  input  evuhp_pkg::in_item_t req_i,
  input  logic                consume_i,
  output logic                item_vld_o,
  output evuhp_pkg::in_item_t item_o
);

  logic                vld_q;
  evuhp_pkg::in_item_t item_q;

  // Take a new request when empty or when the held one leaves this cycle
  assign req_rdy_o = !vld_q || consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (req_vld_i && req_rdy_o) begin
      vld_q <= 1'b1;
    end else if (consume_i) begin
      vld_q <= 1'b0;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (req_vld_i && req_rdy_o) begin
      item_q <= req_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

// ===== rtl/core/evuhp_parse.sv =====
module evuhp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic [15:0]        min_len_i,
  output logic               res_vld_o,
  output evuhp_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhEth,
    PhVlan,
    PhIp,
    PhUdp,
    PhPayload,
    PhReject
  } phase_e;

  // Byte places within the headers
  localparam evuhp_pkg::pos_t EtypeHiPos = 16'd12;
  localparam evuhp_pkg::pos_t EtypeLoPos = 16'd13;
  localparam logic [5:0] VlanTypeHi = 6'd2;
  localparam logic [5:0] VlanTypeLo = 6'd3;
  localparam logic [5:0] IpVerIhl   = 6'd0;
  localparam logic [5:0] IpProto    = 6'd9;
  localparam logic [5:0] IpSrcFirst = 6'd12;
  localparam logic [5:0] IpDstFirst = 6'd16;
  localparam logic [5:0] IpDstEnd   = 6'd20;
  localparam logic [5:0] UdpDport   = 6'd2;
  localparam logic [5:0] UdpLen     = 6'd4;
  localparam logic [5:0] UdpLenEnd  = 6'd6;
  localparam logic [5:0] UdpLastHdr = 6'd7;

  phase_e              phase_q, phase_d;
  evuhp_pkg::pos_t     pos_q, pos_d;
  logic [5:0]          sec_q, sec_d;
  logic [7:0]          etype_hi_q, etype_hi_d;
  logic [5:0]          hdr_bytes_q, hdr_bytes_d;
  logic                proto_ok_q, proto_ok_d;
  logic [31:0]         src_addr_q, src_addr_d;
  logic [31:0]         dst_addr_q, dst_addr_d;
  logic [15:0]         src_port_q, src_port_d;
  logic [15:0]         dst_port_q, dst_port_d;
  logic [15:0]         udp_len_q, udp_len_d;
  evuhp_pkg::pos_t     offset_q, offset_d;
  evuhp_pkg::pos_t     rem_q, rem_d;
  logic                in_range;
  logic [15:0]         etype_now;
  logic [15:0]         len_m8;
  logic                pick_rem;
  evuhp_pkg::result_t  res;

  assign in_range  = pos_q < evuhp_pkg::PosW'(evuhp_pkg::MaxFrameBytes);
  assign etype_now = {etype_hi_q, byte_i};

  // Advance the header walk by one byte
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sec_d       = sec_q;
    etype_hi_d  = etype_hi_q;
    hdr_bytes_d = hdr_bytes_q;
    proto_ok_d  = proto_ok_q;
    src_addr_d  = src_addr_q;
    dst_addr_d  = dst_addr_q;
    src_port_d  = src_port_q;
    dst_port_d  = dst_port_q;
    udp_len_d   = udp_len_q;
    offset_d    = offset_q;
    rem_d       = rem_q;

    if (in_range) begin
      pos_d = pos_q + 1'b1;
      case (phase_q)
        PhEth: begin
          if (pos_q == EtypeHiPos) begin
            etype_hi_d = byte_i;
          end
          if (pos_q == EtypeLoPos) begin
            sec_d   = '0;
            phase_d = (etype_now == evuhp_pkg::EtypeVlan) ? PhVlan :
                      (etype_now == evuhp_pkg::EtypeIpv4) ? PhIp : PhReject;
          end
        end
        PhVlan: begin
          sec_d = sec_q + 1'b1;
          if (sec_q == VlanTypeHi) begin
            etype_hi_d = byte_i;
          end
          if (sec_q == VlanTypeLo) begin
            sec_d   = '0;
            phase_d = (etype_now == evuhp_pkg::EtypeVlan) ? PhVlan :
                      (etype_now == evuhp_pkg::EtypeIpv4) ? PhIp : PhReject;
          end
        end
        PhIp: begin
          sec_d = sec_q + 1'b1;
          if (sec_q == IpVerIhl) begin
            hdr_bytes_d = {byte_i[3:0], 2'b00};
            if (byte_i[3:0] < evuhp_pkg::IhlMin) begin
              phase_d = PhReject;
            end
          end else if (sec_q == IpProto) begin
            proto_ok_d = (byte_i == evuhp_pkg::ProtoUdp);
          end else if (sec_q >= IpSrcFirst && sec_q < IpDstFirst) begin
            src_addr_d = {src_addr_q[23:0], byte_i};
          end else if (sec_q >= IpDstFirst && sec_q < IpDstEnd) begin
            dst_addr_d = {dst_addr_q[23:0], byte_i};
          end
          if (phase_d == PhIp && (sec_q + 1'b1) == hdr_bytes_d) begin
            sec_d   = '0;
            phase_d = PhUdp;
          end
        end
        PhUdp: begin
          sec_d = sec_q + 1'b1;
          if (sec_q < UdpDport) begin
            src_port_d = {src_port_q[7:0], byte_i};
          end else if (sec_q < UdpLen) begin
            dst_port_d = {dst_port_q[7:0], byte_i};
          end else if (sec_q < UdpLenEnd) begin
            udp_len_d = {udp_len_q[7:0], byte_i};
          end
          if (sec_q == UdpLastHdr) begin
            phase_d  = PhPayload;
            offset_d = pos_q + 1'b1;
            rem_d    = '0;
          end
        end
        PhPayload: begin
          rem_d = rem_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Choose payload length: UDP length minus header, else the captured rest
  assign len_m8   = udp_len_q - evuhp_pkg::UdpHeaderBytes;
  assign pick_rem = (udp_len_q < evuhp_pkg::UdpHeaderBytes) ||
                    (len_m8 < min_len_i) || (len_m8 > rem_d);

  always_comb begin
    res = '0;
    if (phase_d == PhPayload && proto_ok_d) begin
      res.accepted       = 1'b1;
      res.source_address = src_addr_d;
      res.dest_address   = dst_addr_d;
      res.source_port    = src_port_d;
      res.dest_port      = dst_port_d;
      res.payload_offset = offset_d;
      res.payload_length = pick_rem ? rem_d : len_m8;
    end
  end

  assign res_vld_o = take_i && last_i;
  assign res_o     = res;

  // Hold per-frame state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhEth;
      pos_q       <= '0;
      sec_q       <= '0;
      etype_hi_q  <= '0;
      hdr_bytes_q <= '0;
      proto_ok_q  <= 1'b0;
      rem_q       <= '0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q     <= PhEth;
        pos_q       <= '0;
        sec_q       <= '0;
        etype_hi_q  <= '0;
        hdr_bytes_q <= '0;
        proto_ok_q  <= 1'b0;
        rem_q       <= '0;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        sec_q       <= sec_d;
        etype_hi_q  <= etype_hi_d;
        hdr_bytes_q <= hdr_bytes_d;
        proto_ok_q  <= proto_ok_d;
        rem_q       <= rem_d;
      end
    end
  end

  // Header fields are fully rewritten before any accepted result uses them
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      src_addr_q <= src_addr_d;
      dst_addr_q <= dst_addr_d;
      src_port_q <= src_port_d;
      dst_port_q <= dst_port_d;
      udp_len_q  <= udp_len_d;
      offset_q   <= offset_d;
    end
  end

endmodule

// ===== rtl/core/evuhp_out_stage.sv =====
module evuhp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_vld_i,
  input  evuhp_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_vld_o,
  input  logic               out_rdy_i,
  output evuhp_pkg::result_t out_o
);

  logic               vld_q;
  evuhp_pkg::result_t res_q;

  // Slot is free when empty or drained this cycle
  assign free_o = !vld_q || out_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_vld_i) begin
      vld_q <= 1'b1;
    end else if (out_rdy_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_vld_o = vld_q;
  assign out_o     = res_q;

endmodule

// ===== rtl/core/eth_vlan_ipv4_udp_header_parser_unit.sv =====
// Ethernet/VLAN/IPv4/UDP header parser. Feed a captured frame one byte per
// request on the slave stream, starting at the destination MAC, with tlast on
// the final byte. Any number of stacked 0x8100 tags are skipped; the frame is
// accepted only as IPv4 with IHL of at least 5, protocol 17 and a complete UDP
// header. Each frame yields exactly one result request on the master stream,
// in the cycle after its last byte is processed: tuser is the accept flag,
// tdata the addresses, ports, payload offset and payload length (all zero on
// reject). Throughput is one byte per clock, the header state being updated
// between the input register and the result register; a stalled result only
// blocks the next frame's last byte. Bytes past 16384 are not counted.
// cfg_wdata_i is written when cfg_we_i is high and sets the minimum payload
// length (reset 240), sampled when the last byte of a frame is processed.
module eth_vlan_ipv4_udp_header_parser_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // frame_byte
  input  logic                               s_axis_tlast,  // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // source_address, dest_address, source_port, dest_port, payload_offset,
  // payload_length (lowest bits first)
  output logic [evuhp_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                               m_axis_tuser,  // accepted
  input  logic                               cfg_we_i,
  input  logic [15:0]                        cfg_wdata_i
);

  evuhp_pkg::in_item_t req;
  evuhp_pkg::in_item_t item;
  evuhp_pkg::result_t  res;
  evuhp_pkg::result_t  out;
  logic                item_vld;
  logic                consume;
  logic                out_free;
  logic                res_vld;
  logic [15:0]         min_len_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= evuhp_pkg::MinPayloadReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  assign req.frame_byte = s_axis_tdata;
  assign req.last_byte  = s_axis_tlast;

  evuhp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_vld_i  (s_axis_tvalid),
    .req_rdy_o  (s_axis_tready),
    .req_i      (req),
    .consume_i  (consume),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  // Process a byte unless it ends a frame while the result slot is full
  assign consume = item_vld && (!item.last_byte || out_free);

  evuhp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (consume),
    .byte_i    (item.frame_byte),
    .last_i    (item.last_byte),
    .min_len_i (min_len_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  evuhp_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_i     (res),
    .free_o    (out_free),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_o     (out)
  );

  assign m_axis_tuser = out.accepted;
  assign m_axis_tdata = {out.payload_length, out.payload_offset, out.dest_port,
                         out.source_port, out.dest_address, out.source_address};

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !res_vld)
    else $error("pending result overwritten");

  // A rejected frame reports all-zero fields
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("rejected result carries data");

  // An accepted payload starts after minimal Ethernet, IPv4 and UDP headers
  a_min_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out.payload_offset >= evuhp_pkg::MinPayloadOffset))
    else $error("payload offset below header size");

  // An empty input register always takes a request
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_vld |-> s_axis_tready)
    else $error("input stalled while empty");

endmodule

// ===== bench/eth_vlan_ipv4_udp_header_parser_unit_test.sv =====
module eth_vlan_ipv4_udp_header_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RxHoldCycles = 200;
  localparam int unsigned IdlePercent  = 28;

  // Header parser phases, tracked by the predictor
  typedef enum logic [2:0] {
    PhEth,
    PhVlan,
    PhIp,
    PhUdp,
    PhPayload,
    PhReject
  } parse_phase_e;

  // Description of one frame to send
  typedef struct {
    bit          noise;
    int          n_tags;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ulen;
    int          payload_n;
    int          cut;
  } frame_spec_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [evuhp_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_we_i      = 1'b0;
  logic [15:0]                   cfg_wdata_i   = '0;

  // Predictor state
  int unsigned         min_payload_cfg;
  int unsigned         frame_pos;
  logic [15:0]         tag_etype;
  int unsigned         ip_base;
  int unsigned         ip_hdr_len;
  logic [7:0]          ip_proto;
  logic [31:0]         ip_src;
  logic [31:0]         ip_dst;
  logic [15:0]         udp_sport;
  logic [15:0]         udp_dport;
  logic [15:0]         udp_len_field;
  parse_phase_e        parse_state;
  evuhp_pkg::result_t  frame_results[$];

  bit steady_mode     = 1'b0;
  int hold_req_count  = 0;
  int hold_seen       = 0;
  int rx_hold_left    = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int bytes_sent      = 0;
  int frames_sent     = 0;
  int results_checked = 0;
  int accepts_seen    = 0;

  eth_vlan_ipv4_udp_header_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("eth_vlan_ipv4_udp_header_parser_unit test failed");
      $finish;
    end
  end

  task automatic report_error(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void clear_frame_state();
    frame_pos     = 0;
    tag_etype     = '0;
    ip_base       = 14;
    ip_hdr_len    = 0;
    ip_proto      = '0;
    ip_src        = '0;
    ip_dst        = '0;
    udp_sport     = '0;
    udp_dport     = '0;
    udp_len_field = '0;
    parse_state   = PhEth;
  endfunction

  function automatic parse_phase_e phase_after_tag(logic [15:0] et);
    if (et == evuhp_pkg::EtypeVlan) return PhVlan;
    if (et == evuhp_pkg::EtypeIpv4) return PhIp;
    return PhReject;
  endfunction

  // Advance the header state by one frame byte; queue the result on the last byte
  function automatic void predict_byte(logic [7:0] b, logic last);
    int unsigned        o;
    int unsigned        offset;
    int unsigned        remain;
    int unsigned        plen;
    evuhp_pkg::result_t res;
    if (frame_pos < evuhp_pkg::MaxFrameBytes) begin
      case (parse_state)
        PhEth: begin
          if (frame_pos == 12 || frame_pos == 13) tag_etype = {tag_etype[7:0], b};
          if (frame_pos == 13) parse_state = phase_after_tag(tag_etype);
        end
        PhVlan: begin
          o = frame_pos - ip_base;
          if (o == 2 || o == 3) tag_etype = {tag_etype[7:0], b};
          if (o == 3) begin
            ip_base += 4;
            parse_state = phase_after_tag(tag_etype);
          end
        end
        PhIp: begin
          o = frame_pos - ip_base;
          if (o == 0) begin
            ip_hdr_len = {b[3:0], 2'b00};
            if (ip_hdr_len < 4 * evuhp_pkg::IhlMin) parse_state = PhReject;
          end else if (o == 9) begin
            ip_proto = b;
          end else if (o >= 12 && o < 16) begin
            ip_src = {ip_src[23:0], b};
          end else if (o >= 16 && o < 20) begin
            ip_dst = {ip_dst[23:0], b};
          end
          if (parse_state == PhIp && o + 1 == ip_hdr_len) parse_state = PhUdp;
        end
        PhUdp: begin
          o = frame_pos - ip_base - ip_hdr_len;
          if (o < 2) udp_sport = {udp_sport[7:0], b};
          else if (o < 4) udp_dport = {udp_dport[7:0], b};
          else if (o < 6) udp_len_field = {udp_len_field[7:0], b};
          if (o == 7) parse_state = PhPayload;
        end
        default: ;
      endcase
      frame_pos++;
    end
    if (last) begin
      res = '0;
      if (parse_state == PhPayload && ip_proto == evuhp_pkg::ProtoUdp) begin
        offset = ip_base + ip_hdr_len + evuhp_pkg::UdpHeaderBytes;
        remain = frame_pos - offset;
        if (udp_len_field < evuhp_pkg::UdpHeaderBytes) begin
          plen = remain;
        end else begin
          plen = udp_len_field - evuhp_pkg::UdpHeaderBytes;
          if (plen < min_payload_cfg || plen > remain) plen = remain;
        end
        res.accepted       = 1'b1;
        res.source_address = ip_src;
        res.dest_address   = ip_dst;
        res.source_port    = udp_sport;
        res.dest_port      = udp_dport;
        res.payload_offset = offset[15:0];
        res.payload_length = plen[15:0];
      end
      frame_results.push_back(res);
      clear_frame_state();
    end
  endfunction

  // Compare one result request with the oldest pending frame
  task automatic check_result();
    evuhp_pkg::result_t got;
    evuhp_pkg::result_t want;
    got.accepted       = m_axis_tuser;
    got.source_address = m_axis_tdata[31:0];
    got.dest_address   = m_axis_tdata[63:32];
    got.source_port    = m_axis_tdata[79:64];
    got.dest_port      = m_axis_tdata[95:80];
    got.payload_offset = m_axis_tdata[111:96];
    got.payload_length = m_axis_tdata[127:112];
    results_checked++;
    if (got.accepted === 1'b1) accepts_seen++;
    if (frame_results.size() == 0) begin
      report_error("result with no frame pending");
    end else begin
      want = frame_results.pop_front();
      if (got.accepted !== want.accepted)
        report_error($sformatf("result %0d accepted: got %0h expected %0h",
                               results_checked, got.accepted, want.accepted));
      if (got.source_address !== want.source_address)
        report_error($sformatf("result %0d source_address: got %0h expected %0h",
                               results_checked, got.source_address, want.source_address));
      if (got.dest_address !== want.dest_address)
        report_error($sformatf("result %0d dest_address: got %0h expected %0h",
                               results_checked, got.dest_address, want.dest_address));
      if (got.source_port !== want.source_port)
        report_error($sformatf("result %0d source_port: got %0h expected %0h",
                               results_checked, got.source_port, want.source_port));
      if (got.dest_port !== want.dest_port)
        report_error($sformatf("result %0d dest_port: got %0h expected %0h",
                               results_checked, got.dest_port, want.dest_port));
      if (got.payload_offset !== want.payload_offset)
        report_error($sformatf("result %0d payload_offset: got %0d expected %0d",
                               results_checked, got.payload_offset, want.payload_offset));
      if (got.payload_length !== want.payload_length)
        report_error($sformatf("result %0d payload_length: got %0d expected %0d",
                               results_checked, got.payload_length, want.payload_length));
    end
  endtask

  // Result side: check each request, drive tready with random stalls and hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req_count) begin
      hold_seen    = hold_req_count;
      rx_hold_left = RxHoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_mode || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Offer one byte request, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic last);
    while (!steady_mode && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  // Build the frame bytes from a description and stream them
  task automatic send_frame(frame_spec_t s);
    logic [7:0] fb[$];
    int         hdr_n;
    int         i;
    if (s.noise) begin
      repeat (s.payload_n) fb.push_back(8'($urandom));
    end else begin
      repeat (12) fb.push_back(8'($urandom));
      repeat (s.n_tags) begin
        fb.push_back(evuhp_pkg::EtypeVlan[15:8]);
        fb.push_back(evuhp_pkg::EtypeVlan[7:0]);
        fb.push_back(8'($urandom));
        fb.push_back(8'($urandom));
      end
      fb.push_back(s.etype[15:8]);
      fb.push_back(s.etype[7:0]);
      hdr_n = (s.ihl < evuhp_pkg::IhlMin) ? 20 : 4 * int'(s.ihl);
      for (i = 0; i < hdr_n; i++) begin
        if (i == 0) fb.push_back({4'($urandom), s.ihl});
        else if (i == 9) fb.push_back(s.proto);
        else if (i >= 12 && i < 16) fb.push_back(s.src[8*(15-i) +: 8]);
        else if (i >= 16 && i < 20) fb.push_back(s.dst[8*(19-i) +: 8]);
        else fb.push_back(8'($urandom));
      end
      fb.push_back(s.sport[15:8]);
      fb.push_back(s.sport[7:0]);
      fb.push_back(s.dport[15:8]);
      fb.push_back(s.dport[7:0]);
      fb.push_back(s.ulen[15:8]);
      fb.push_back(s.ulen[7:0]);
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
      repeat (s.payload_n) fb.push_back(8'($urandom));
      if (s.cut > 0 && s.cut < fb.size()) fb = fb[0:s.cut-1];
    end
    for (i = 0; i < fb.size(); i++) send_byte(fb[i], i == fb.size() - 1);
    frames_sent++;
  endtask

  // Well-formed untagged IPv4/UDP frame with random addresses and ports
  function automatic frame_spec_t udp_spec(int payload_n);
    frame_spec_t s;
    s.noise     = 1'b0;
    s.n_tags    = 0;
    s.etype     = evuhp_pkg::EtypeIpv4;
    s.ihl       = evuhp_pkg::IhlMin;
    s.proto     = evuhp_pkg::ProtoUdp;
    s.src       = $urandom;
    s.dst       = $urandom;
    s.sport     = 16'($urandom);
    s.dport     = 16'($urandom);
    s.ulen      = 16'(payload_n) + evuhp_pkg::UdpHeaderBytes;
    s.payload_n = payload_n;
    s.cut       = 0;
    return s;
  endfunction

  // Drop valid and wait for every pending result, then let the pipe settle
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_min_payload(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_payload_cfg = v;
  endtask

  task automatic test_header_fields();
    frame_spec_t s;
    send_frame(udp_spec(0));
    s           = udp_spec(3);
    s.ihl       = 4'hF;
    s.src       = '1;
    s.dst       = '1;
    s.sport     = '1;
    s.dport     = '1;
    s.ulen      = '1;
    send_frame(s);
    s           = udp_spec(2);
    s.src       = '0;
    s.dst       = '0;
    s.sport     = '0;
    s.dport     = '0;
    s.ulen      = '0;
    send_frame(s);
    s           = udp_spec(5);
    s.n_tags    = 3;
    send_frame(s);
    s           = udp_spec(4);
    s.n_tags    = 40;
    send_frame(s);
  endtask

  task automatic test_rejected_frames();
    frame_spec_t s;
    s           = udp_spec(0);
    s.noise     = 1'b1;
    s.payload_n = 1;
    send_frame(s);
    // end inside the EtherType and right at its end
    s           = udp_spec(4);
    s.cut       = 13;
    send_frame(s);
    s.cut       = 14;
    send_frame(s);
    // end inside a tag, the IPv4 header and the UDP header
    s.n_tags    = 1;
    s.cut       = 16;
    send_frame(s);
    s.n_tags    = 0;
    s.cut       = 24;
    send_frame(s);
    s.cut       = 41;
    send_frame(s);
    // ends right after the UDP header: accepted with no payload
    s.cut       = 42;
    send_frame(s);
    s           = udp_spec(6);
    s.etype     = 16'h86DD;
    send_frame(s);
    s.etype     = 16'h0000;
    send_frame(s);
    s           = udp_spec(6);
    s.proto     = 8'd6;
    send_frame(s);
    s.proto     = 8'hFF;
    send_frame(s);
    s           = udp_spec(6);
    s.ihl       = 4'd0;
    send_frame(s);
    s.ihl       = evuhp_pkg::IhlMin - 1;
    send_frame(s);
  endtask

  task automatic test_payload_length_select();
    frame_spec_t s;
    wait_until_drained();
    set_min_payload(16'd0);
    s      = udp_spec(10);
    send_frame(s);
    s.ulen = 16'd15;
    send_frame(s);
    s.ulen = 16'd40;
    send_frame(s);
    s.ulen = 16'd5;
    send_frame(s);
    wait_until_drained();
    set_min_payload(16'd7);
    s.ulen = 16'd15;
    send_frame(s);
    s.ulen = 16'd14;
    send_frame(s);
    wait_until_drained();
    set_min_payload(16'hFFFF);
    s.ulen = 16'hFFFF;
    send_frame(s);
    wait_until_drained();
    set_min_payload(evuhp_pkg::MinPayloadReset);
  endtask

  // Stall the result side long enough that frames pile up at the input
  task automatic test_back_pressure();
    frame_spec_t s;
    int          k;
    hold_req_count++;
    for (k = 0; k < 8; k++) begin
      s = udp_spec($urandom_range(0, 3));
      if (k % 2 == 0) begin
        s.noise     = 1'b1;
        s.payload_n = $urandom_range(1, 3);
      end
      send_frame(s);
    end
  endtask

  task automatic test_random_frames();
    frame_spec_t s;
    int          n_frames;
    int          batch;
    n_frames    = 0;
    batch       = 0;
    while (n_frames < 15) begin
      // new payload minimum every batch; one batch runs without idling
      if (n_frames % 3 == 0) begin
        wait_until_drained();
        case (batch % 5)
          0: set_min_payload(16'd0);
          1: set_min_payload(16'hFFFF);
          2: set_min_payload(16'($urandom_range(0, 24)));
          3: set_min_payload(evuhp_pkg::MinPayloadReset);
          default: set_min_payload(16'($urandom));
        endcase
        steady_mode = (batch == 2);
        batch++;
      end
      s = udp_spec($urandom_range(0, 24));
      if ($urandom_range(99) < 65) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: s.n_tags = 0;
          6, 7, 8: s.n_tags = 1;
          default: s.n_tags = $urandom_range(2, 4);
        endcase
        if ($urandom_range(1)) s.ihl = 4'($urandom_range(5, 15));
        case ($urandom_range(4))
          0: s.ulen = 16'(s.payload_n) + evuhp_pkg::UdpHeaderBytes;
          1: s.ulen = 16'($urandom_range(0, 7));
          2: s.ulen = 16'(s.payload_n + 8 + $urandom_range(1, 10));
          3: s.ulen = 16'($urandom_range(8, s.payload_n + 8));
          default: s.ulen = 16'($urandom);
        endcase
      end else begin
        case ($urandom_range(4))
          0: begin
            s.n_tags = $urandom_range(0, 2);
            s.ihl    = 4'($urandom_range(5, 15));
            s.cut    = $urandom_range(1, 22 + 4 * s.n_tags + 4 * int'(s.ihl));
          end
          1: begin
            s.etype = 16'($urandom);
            if (s.etype == evuhp_pkg::EtypeVlan || s.etype == evuhp_pkg::EtypeIpv4)
              s.etype ^= 16'h0001;
          end
          2: begin
            s.proto = 8'($urandom);
            if (s.proto == evuhp_pkg::ProtoUdp) s.proto = evuhp_pkg::ProtoUdp + 8'd1;
          end
          3: s.ihl = 4'($urandom_range(0, 4));
          default: begin
            s.noise     = 1'b1;
            s.payload_n = $urandom_range(1, 60);
          end
        endcase
      end
      send_frame(s);
      n_frames++;
    end
    steady_mode = 1'b0;
  endtask

  initial begin
    int n;
    min_payload_cfg = evuhp_pkg::MinPayloadReset;
    clear_frame_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_fields();
    test_rejected_frames();
    test_payload_length_select();
    test_back_pressure();
    test_random_frames();

    // Collect the tail, then watch for stray results
    s_axis_tvalid <= 1'b0;
    for (n = 0; n < 5000 && frame_results.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (frame_results.size() != 0)
      report_error($sformatf("%0d results never arrived", frame_results.size()));

    $display("Sent %0d frames (%0d bytes); checked %0d results, %0d accepted.",
             frames_sent, bytes_sent, results_checked, accepts_seen);
    $display("Covered tags, truncation, bad type/protocol/IHL, payload length choice, stalls.");
    if (error_count == 0) begin
      $display("eth_vlan_ipv4_udp_header_parser_unit test passed");
    end else begin
      $display("eth_vlan_ipv4_udp_header_parser_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/evuhp_pkg.sv
rtl/core/evuhp_in_stage.sv
rtl/core/evuhp_parse.sv
rtl/core/evuhp_out_stage.sv
rtl/core/eth_vlan_ipv4_udp_header_parser_unit.sv
bench/eth_vlan_ipv4_udp_header_parser_unit_test.sv
